[rtl/core/sbbi_pkg.sv]
// ----------------------------------------------------------------------------
// sbbi_pkg
// Shared types and constants for the sprite/background bus window.
// ----------------------------------------------------------------------------
package sbbi_pkg;

   localparam int unsigned MEM_WORDS = 32768;
   localparam int unsigned MEM_AW    = 15;

   // access kinds
   localparam logic [1:0] REQ_RD_BYTE = 2'd0;
   localparam logic [1:0] REQ_RD_WORD = 2'd1;
   localparam logic [1:0] REQ_WR_BYTE = 2'd2;
   localparam logic [1:0] REQ_WR_WORD = 2'd3;

   // notify codes
   localparam logic [2:0] NTF_NONE  = 3'd0;
   localparam logic [2:0] NTF_SPR   = 3'd1;
   localparam logic [2:0] NTF_PAT   = 3'd2;
   localparam logic [2:0] NTF_PATBG = 3'd3;
   localparam logic [2:0] NTF_CTRL  = 3'd4;

   // control word indexes
   localparam logic [3:0] CW_SCROLL_X0 = 4'd0;
   localparam logic [3:0] CW_SCROLL_Y0 = 4'd1;
   localparam logic [3:0] CW_SCROLL_X1 = 4'd2;
   localparam logic [3:0] CW_SCROLL_Y1 = 4'd3;
   localparam logic [3:0] CW_ENABLE    = 4'd4;
   localparam logic [3:0] CW_H_TOTAL   = 4'd5;
   localparam logic [3:0] CW_H_DISP    = 4'd6;
   localparam logic [3:0] CW_V_DISP    = 4'd7;
   localparam logic [3:0] CW_RES       = 4'd8;

   // window map
   localparam logic [15:0] SPR_END  = 16'h0400;
   localparam logic [15:0] CTRL_LO  = 16'h0800;
   localparam logic [15:0] CTRL_END = 16'h0812;
   localparam logic [15:0] PAT_LO   = 16'h8000;
   localparam logic [15:0] PATBG_LO = 16'hC000;

   // config register indexes
   localparam logic [0:0] CSR_CONNECTED = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic accept;
      logic commit;
      logic clear_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/core/sbbi_csr.sv]
// ----------------------------------------------------------------------------
// sbbi_csr
// Configuration register file: the connected flag.
// ----------------------------------------------------------------------------
module sbbi_csr import sbbi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        connected
);

   logic connected_ff;
   logic connected_in;
   logic reg_idx;

   assign reg_idx = 1'(paddr >> 2);

   always_comb begin
      connected_in = connected_ff;
      if (psel && penable && pwrite && (reg_idx == CSR_CONNECTED)) begin
         connected_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
      end else begin
         connected_ff <= connected_in;
      end
   end

   assign prdata    = {31'd0, connected_ff};
   assign pready    = 1'b1;
   assign connected = connected_ff;

endmodule

[rtl/core/sbbi_ctrl.sv]
// ----------------------------------------------------------------------------
// sbbi_ctrl
// Sequencer: post-reset store clear, item capture, execute/commit.
// ----------------------------------------------------------------------------
module sbbi_ctrl import sbbi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

[rtl/core/sbbi_dp.sv]
// ----------------------------------------------------------------------------
// sbbi_dp
// Datapath: window store, access decode, control fields, result register.
// ----------------------------------------------------------------------------
module sbbi_dp import sbbi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          connected,
   input  logic [1:0]    req_type,
   input  logic [15:0]   req_addr,
   input  logic [15:0]   req_wdata,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [15:0]   rsp_rdata,
   output logic          rsp_bus_error,
   output logic [2:0]    rsp_wait_cycles,
   output logic [2:0]    rsp_notify_kind,
   output logic [3:0]    rsp_ctrl_index
);

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] rd_q_ff;

   logic [1:0]        typ_ff;
   logic [15:0]       addr_ff;
   logic [15:0]       wdata_ff;
   logic [MEM_AW-1:0] clr_cnt_ff;

   // control fields
   logic [9:0] scroll_x_ff [2];
   logic [9:0] scroll_y_ff [2];
   logic       display_on_ff;
   logic [1:0] plane_area_ff [2];
   logic       plane_on_ff [2];
   logic [7:0] horiz_total_ff;
   logic [5:0] horiz_display_ff;
   logic [7:0] vert_display_ff;
   logic [1:0] horiz_res_ff;
   logic [1:0] vert_res_ff;
   logic       low_res_ff;
   logic       tile_large_ff;

   logic        rsp_valid_ff;
   logic [15:0] rdata_ff;
   logic        err_ff;
   logic [2:0]  wait_ff;
   logic [2:0]  kind_ff;
   logic [3:0]  cidx_ff;

   logic              in_ctrl, resv_hi, resv_lo, rd_free;
   logic [15:0]       cur_word, new_word;
   logic [7:0]        cur_byte;
   logic [2:0]        wait_amt, notify;
   logic [3:0]        cidx;
   logic [15:0]       res_rdata;
   logic              res_err;
   logic [2:0]        res_wait, res_kind;
   logic [3:0]        res_cidx;
   logic              wr_en, ctrl_wr;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_wa;
   logic [15:0]       mem_wd;

   // item capture, word accesses ignore bit 0
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         typ_ff   <= req_type;
         addr_ff  <= {req_addr[15:1], req_addr[0] & ~req_type[0]};
         wdata_ff <= req_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign status.clear_last = &clr_cnt_ff;

   // decode
   always_comb begin
      in_ctrl  = (addr_ff >= CTRL_LO) && (addr_ff < CTRL_END);
      resv_hi  = (addr_ff >= CTRL_END) && (addr_ff < PAT_LO);
      resv_lo  = (addr_ff >= SPR_END) && (addr_ff < CTRL_LO);
      rd_free  = (addr_ff >= CTRL_LO) && (addr_ff < PAT_LO);
      cur_word = (resv_hi || resv_lo) ? 16'hFFFF : rd_q_ff;
      cur_byte = addr_ff[0] ? cur_word[7:0] : cur_word[15:8];
      wait_amt = display_on_ff ? 3'd4 : 3'd2;
      cidx     = addr_ff[4:1];
      if (addr_ff < SPR_END) begin
         notify = NTF_SPR;
      end else if (addr_ff >= PATBG_LO) begin
         notify = NTF_PATBG;
      end else if (addr_ff >= PAT_LO) begin
         notify = NTF_PAT;
      end else begin
         notify = NTF_NONE;
      end
   end

   // access execution
   always_comb begin
      res_rdata = 16'd0;
      res_err   = 1'b0;
      res_wait  = 3'd0;
      res_kind  = NTF_NONE;
      res_cidx  = 4'd0;
      wr_en     = 1'b0;
      ctrl_wr   = 1'b0;
      new_word  = wdata_ff;
      unique case (typ_ff)
         REQ_RD_BYTE, REQ_RD_WORD: begin
            if (!rd_free && !connected) begin
               res_err   = 1'b1;
               res_rdata = 16'h00FF;
            end else begin
               res_rdata = (typ_ff == REQ_RD_BYTE) ? {8'd0, cur_byte} : cur_word;
               if (!rd_free && ((typ_ff == REQ_RD_WORD) || addr_ff[0])) begin
                  res_wait = wait_amt;
               end
            end
         end
         REQ_WR_BYTE: begin
            new_word = addr_ff[0] ? {cur_word[15:8], wdata_ff[7:0]}
                                  : {wdata_ff[7:0], cur_word[7:0]};
            if (cur_byte == wdata_ff[7:0]) begin
               res_kind = NTF_NONE;
            end else if (in_ctrl) begin
               wr_en    = 1'b1;
               ctrl_wr  = 1'b1;
               res_kind = NTF_CTRL;
               res_cidx = cidx;
            end else if (resv_hi) begin
               res_kind = NTF_NONE;
            end else if (!connected) begin
               res_err   = 1'b1;
               res_rdata = 16'h00FF;
            end else begin
               if (addr_ff[0]) begin
                  res_wait = wait_amt;
               end
               if (!resv_lo) begin
                  wr_en    = 1'b1;
                  res_kind = notify;
               end
            end
         end
         REQ_WR_WORD: begin
            if (cur_word == wdata_ff) begin
               res_kind = NTF_NONE;
            end else if (in_ctrl) begin
               wr_en    = 1'b1;
               ctrl_wr  = 1'b1;
               res_kind = NTF_CTRL;
               res_cidx = cidx;
            end else if (resv_hi) begin
               res_kind = NTF_NONE;
            end else begin
               res_wait = wait_amt;
               if (!resv_lo) begin
                  wr_en    = 1'b1;
                  res_kind = notify;
               end
            end
         end
         default: begin
            res_kind = NTF_NONE;
         end
      endcase
   end

   // store port
   assign mem_we = cmd.clear_step || (cmd.commit && wr_en);
   assign mem_wa = cmd.clear_step ? clr_cnt_ff : addr_ff[15:1];
   assign mem_wd = cmd.clear_step ? 16'd0 : new_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.accept) begin
         rd_q_ff <= mem[req_addr[15:1]];
      end
   end

   // control field decode
   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff[0]   <= '0;
         scroll_x_ff[1]   <= '0;
         scroll_y_ff[0]   <= '0;
         scroll_y_ff[1]   <= '0;
         display_on_ff    <= 1'b0;
         plane_area_ff[0] <= '0;
         plane_area_ff[1] <= '0;
         plane_on_ff[0]   <= 1'b0;
         plane_on_ff[1]   <= 1'b0;
         horiz_total_ff   <= '0;
         horiz_display_ff <= '0;
         vert_display_ff  <= '0;
         horiz_res_ff     <= '0;
         vert_res_ff      <= '0;
         low_res_ff       <= 1'b0;
         tile_large_ff    <= 1'b0;
      end else if (cmd.commit && ctrl_wr) begin
         unique case (cidx)
            CW_SCROLL_X0: scroll_x_ff[0] <= new_word[9:0];
            CW_SCROLL_Y0: scroll_y_ff[0] <= new_word[9:0];
            CW_SCROLL_X1: scroll_x_ff[1] <= new_word[9:0];
            CW_SCROLL_Y1: scroll_y_ff[1] <= new_word[9:0];
            CW_ENABLE: begin
               display_on_ff    <= new_word[9];
               plane_area_ff[1] <= new_word[5:4];
               plane_on_ff[1]   <= new_word[3];
               plane_area_ff[0] <= new_word[2:1];
               plane_on_ff[0]   <= new_word[0];
            end
            CW_H_TOTAL: horiz_total_ff   <= new_word[7:0];
            CW_H_DISP:  horiz_display_ff <= new_word[5:0];
            CW_V_DISP:  vert_display_ff  <= new_word[7:0];
            CW_RES: begin
               horiz_res_ff  <= new_word[1:0];
               vert_res_ff   <= new_word[3:2];
               low_res_ff    <= ~new_word[4];
               tile_large_ff <= |new_word[1:0];
            end
            default: begin
               tile_large_ff <= tile_large_ff;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rdata_ff <= res_rdata;
         err_ff   <= res_err;
         wait_ff  <= res_wait;
         kind_ff  <= res_kind;
         cidx_ff  <= res_cidx;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rdata       = rdata_ff;
   assign rsp_bus_error   = err_ff;
   assign rsp_wait_cycles = wait_ff;
   assign rsp_notify_kind = kind_ff;
   assign rsp_ctrl_index  = cidx_ff;

endmodule

[rtl/core/sprite_bg_bus_interface_top.sv]
// ----------------------------------------------------------------------------
// sprite_bg_bus_interface_top
// Bus window onto sprite/background store and display control words.
//
// Usage:
//   req_* carries one bus access (type, addr, wdata) per item; rsp_* returns
//   one result item per access: read data, bus error, wait states, notify
//   code and control word index. Both channels use valid/stall.
//   The APB port holds the connected flag at byte address 0.
// Timing:
//   Accepting an item issues the store read; the execute step then does the
//   decode and read-modify-write and loads the result register, which raises
//   rsp_valid. A new item is accepted only after the current one commits;
//   req_stall stays high in the execute step.
//   A result held by rsp_stall keeps the block in the execute step until the
//   result register is taken; the next request is then accepted.
// Reset:
//   Synchronous. After reset all 32768 store words are cleared, one word a
//   cycle, with req_stall high; APB writes are taken during that pass.
// ----------------------------------------------------------------------------
module sprite_bg_bus_interface_top import sbbi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_addr,
   input  logic [15:0] req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_rdata,
   output logic        rsp_bus_error,
   output logic [2:0]  rsp_wait_cycles,
   output logic [2:0]  rsp_notify_kind,
   output logic [3:0]  rsp_ctrl_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          connected;

   sbbi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .connected (connected)
   );

   sbbi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sbbi_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .connected       (connected),
      .req_type        (req_type),
      .req_addr        (req_addr),
      .req_wdata       (req_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rdata       (rsp_rdata),
      .rsp_bus_error   (rsp_bus_error),
      .rsp_wait_cycles (rsp_wait_cycles),
      .rsp_notify_kind (rsp_notify_kind),
      .rsp_ctrl_index  (rsp_ctrl_index)
   );

endmodule

[rtl/core/sbbi_checker.sv]
// ----------------------------------------------------------------------------
// sbbi_checker
// Port-level checks for the bus window, bound to the top level.
// ----------------------------------------------------------------------------
module sbbi_checker import sbbi_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic [15:0] rsp_rdata,
   input logic        rsp_bus_error,
   input logic [2:0]  rsp_wait_cycles,
   input logic [2:0]  rsp_notify_kind,
   input logic [3:0]  rsp_ctrl_index
);

   // store clear holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during store clear");

   // one item in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is executing");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bus_error) |->
         (rsp_rdata == 16'h00FF && rsp_notify_kind == NTF_NONE))
      else $error("bus error item with data or notify");

   a_wait_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_wait_cycles == 3'd0 || rsp_wait_cycles == 3'd2 || rsp_wait_cycles == 3'd4))
      else $error("bad wait count");

   a_ctrl_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_notify_kind != NTF_CTRL) |-> (rsp_ctrl_index == 4'd0))
      else $error("control index without control notify");

endmodule

bind sprite_bg_bus_interface_top sbbi_checker u_sbbi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_rdata       (rsp_rdata),
   .rsp_bus_error   (rsp_bus_error),
   .rsp_wait_cycles (rsp_wait_cycles),
   .rsp_notify_kind (rsp_notify_kind),
   .rsp_ctrl_index  (rsp_ctrl_index)
);

[test/sprite_bg_bus_interface_top_tb.sv]
// ----------------------------------------------------------------------------
// sprite_bg_bus_interface_top_tb
// Self-checking bench for the sprite/background bus window.
//
// Drives byte and word reads and writes over the req_ channel and checks every
// rsp_ item against a predictor. The predictor keeps its own copy of the
// 32K x 16 store, the connected flag and the display enable. A directed
// sequence covers the window regions and the corner cases. Random phases
// follow, with and without idling on either side, and with the connected flag
// both set and clear. One receiver hold-off fills the block. One sender pause
// drains it.
// ----------------------------------------------------------------------------
module sprite_bg_bus_interface_top_tb;
   import sbbi_pkg::*;

   localparam int WATCHDOG_LIMIT = 100000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS = 170;

   typedef struct packed {
      logic [15:0] rdata;
      logic        bus_error;
      logic [2:0]  wait_cycles;
      logic [2:0]  notify_kind;
      logic [3:0]  ctrl_index;
   } bus_result_type;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [15:0] data;
   } bus_access_type;

   class window_predictor;
      logic [15:0]    store [MEM_WORDS];
      bit             connected;
      bit             display_on;
      bus_result_type pending_results[$];
      int             mismatches;

      function new();
         int i;
         for (i = 0; i < MEM_WORDS; i++) begin
            store[i] = ((i >= 'h200 && i < 'h400) || (i >= 'h409 && i < 'h4000)) ?
                       16'hFFFF : 16'h0000;
         end
         connected = 1'b0;
         display_on = 1'b0;
         mismatches = 0;
      endfunction

      function logic [7:0] byte_at(logic [15:0] a);
         return a[0] ? store[a[15:1]][7:0] : store[a[15:1]][15:8];
      endfunction

      function void put_byte(logic [15:0] a, logic [7:0] b);
         if (a[0]) begin
            store[a[15:1]][7:0] = b;
         end else begin
            store[a[15:1]][15:8] = b;
         end
      endfunction

      function logic [2:0] notify_for(logic [15:0] a);
         if (a < SPR_END) return NTF_SPR;
         if (a >= PATBG_LO) return NTF_PATBG;
         if (a >= PAT_LO) return NTF_PAT;
         return NTF_NONE;
      endfunction

      // only the display enable is visible at the ports (it sets the wait count)
      function void decode_control(logic [3:0] idx, logic [15:0] d);
         if (idx == CW_ENABLE) display_on = d[9];
      endfunction

      function void take_access(logic [1:0] kind, logic [15:0] addr_in, logic [15:0] wd);
         bus_result_type r;
         logic [15:0] a;
         logic [2:0]  wait_amt;
         bit          in_ctrl, in_resv_hi, in_resv_lo;
         r = '0;
         a = addr_in;
         if (kind == REQ_RD_WORD || kind == REQ_WR_WORD) a[0] = 1'b0;
         in_ctrl = a >= CTRL_LO && a < CTRL_END;
         in_resv_hi = a >= CTRL_END && a < PAT_LO;
         in_resv_lo = a >= SPR_END && a < CTRL_LO;
         wait_amt = display_on ? 3'd4 : 3'd2;
         case (kind)
            REQ_RD_BYTE, REQ_RD_WORD: begin
               if (a >= CTRL_LO && a < PAT_LO) begin
                  r.rdata = kind == REQ_RD_BYTE ? {8'h00, byte_at(a)} : store[a[15:1]];
               end else if (!connected) begin
                  r.bus_error = 1'b1;
                  r.rdata = 16'h00FF;
               end else begin
                  if (kind == REQ_RD_WORD || a[0]) r.wait_cycles = wait_amt;
                  r.rdata = kind == REQ_RD_BYTE ? {8'h00, byte_at(a)} : store[a[15:1]];
               end
            end
            REQ_WR_BYTE: begin
               if (byte_at(a) == wd[7:0]) begin
                  // unchanged: nothing happens
               end else if (in_ctrl) begin
                  put_byte(a, wd[7:0]);
                  r.ctrl_index = 4'((a - CTRL_LO) >> 1);
                  decode_control(r.ctrl_index, store[a[15:1]]);
                  r.notify_kind = NTF_CTRL;
               end else if (in_resv_hi) begin
                  // dropped
               end else if (!connected) begin
                  r.bus_error = 1'b1;
                  r.rdata = 16'h00FF;
               end else begin
                  if (a[0]) r.wait_cycles = wait_amt;
                  if (!in_resv_lo) begin
                     put_byte(a, wd[7:0]);
                     r.notify_kind = notify_for(a);
                  end
               end
            end
            default: begin
               if (store[a[15:1]] == wd) begin
                  // unchanged
               end else if (in_ctrl) begin
                  store[a[15:1]] = wd;
                  r.ctrl_index = 4'((a - CTRL_LO) >> 1);
                  decode_control(r.ctrl_index, wd);
                  r.notify_kind = NTF_CTRL;
               end else if (in_resv_hi) begin
                  // dropped
               end else begin
                  r.wait_cycles = wait_amt;
                  if (!in_resv_lo) begin
                     store[a[15:1]] = wd;
                     r.notify_kind = notify_for(a);
                  end
               end
            end
         endcase
         pending_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task match_result(bus_result_type got);
         bus_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item rdata=%h err=%b wait=%0d ntf=%0d idx=%0d",
               got.rdata, got.bus_error, got.wait_cycles, got.notify_kind, got.ctrl_index));
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            report_mismatch($sformatf(
               "rdata %h/%h err %b/%b wait %0d/%0d ntf %0d/%0d idx %0d/%0d (got/exp)",
               got.rdata, want.rdata, got.bus_error, want.bus_error,
               got.wait_cycles, want.wait_cycles, got.notify_kind, want.notify_kind,
               got.ctrl_index, want.ctrl_index));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_RD_BYTE;
   logic [15:0] req_addr = '0;
   logic [15:0] req_wdata = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_rdata;
   logic        rsp_bus_error;
   logic [2:0]  rsp_wait_cycles;
   logic [2:0]  rsp_notify_kind;
   logic [3:0]  rsp_ctrl_index;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   window_predictor predictor = new();

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_offs_asked = 0;
   int hold_offs_done = 0;
   int quiet_cycles = 0;
   bus_access_type last_write;
   bit have_last_write = 1'b0;

   sprite_bg_bus_interface_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // item tracking: note accepted accesses first, then check results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predictor.take_access(req_type, req_addr, req_wdata);
         if (rsp_valid && !rsp_stall) begin
            predictor.match_result({rsp_rdata, rsp_bus_error, rsp_wait_cycles,
                                    rsp_notify_kind, rsp_ctrl_index});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : receiver
      int i;
      forever begin
         @(posedge clock);
         if (hold_offs_asked != hold_offs_done) begin
            hold_offs_done++;
            rsp_stall <= 1'b1;
            for (i = 0; i < HOLD_OFF_CYCLES; i++) @(posedge clock);
         end else begin
            rsp_stall <= $urandom_range(0, 99) < receiver_stall_pct;
         end
      end
   end

   task send_access(bus_access_type acc);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= acc.kind;
      req_addr <= acc.addr;
      req_wdata <= acc.data;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (predictor.pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task write_connected(bit value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 2'(4 * CSR_CONNECTED);
      pwdata <= {31'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      predictor.connected = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task pick_access(output bus_access_type acc);
      acc.kind = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0: acc.addr = 16'($urandom_range(0, 31));
         1: acc.addr = 16'h03E0 + 16'($urandom_range(0, 31));
         2: acc.addr = ($urandom_range(0, 1) ? 16'h0400 : 16'h07F0) + 16'($urandom_range(0, 15));
         3, 4: acc.addr = CTRL_LO + 16'($urandom_range(0, 19));
         5: acc.addr = 16'($urandom_range(CTRL_END, 16'h7FFF));
         6: acc.addr = PAT_LO + 16'($urandom_range(0, 31));
         7: acc.addr = 16'hFFE0 + 16'($urandom_range(0, 31));
         default: acc.addr = 16'($urandom());
      endcase
      case ($urandom_range(0, 7))
         0: acc.data = 16'h0000;
         1: acc.data = 16'hFFFF;
         default: acc.data = 16'($urandom());
      endcase
      // replay the previous write now and then so unchanged writes occur
      if (have_last_write && $urandom_range(0, 6) == 0) acc = last_write;
      if (acc.kind == REQ_WR_BYTE || acc.kind == REQ_WR_WORD) begin
         last_write = acc;
         have_last_write = 1'b1;
      end
   endtask

   task send_random(int count);
      bus_access_type acc;
      int i;
      for (i = 0; i < count; i++) begin
         pick_access(acc);
         send_access(acc);
      end
   endtask

   bus_access_type offline_seq[] = '{
      '{REQ_RD_BYTE, 16'h0001, 16'h0000},
      '{REQ_RD_WORD, 16'h0800, 16'h0000},
      '{REQ_RD_BYTE, 16'h7FFF, 16'h0000},
      '{REQ_WR_BYTE, 16'h0003, 16'hAB00},
      '{REQ_WR_BYTE, 16'h0003, 16'h005A},
      '{REQ_WR_WORD, 16'h0005, 16'hFFFF},
      '{REQ_WR_BYTE, 16'h0811, 16'h00FF},
      '{REQ_WR_WORD, 16'h0808, 16'h0200},
      '{REQ_WR_BYTE, 16'h1000, 16'h0012},
      '{REQ_WR_WORD, 16'h0400, 16'h1234}
   };

   bus_access_type online_seq[] = '{
      '{REQ_RD_WORD, 16'h0005, 16'h0000},
      '{REQ_RD_BYTE, 16'h0004, 16'h0000},
      '{REQ_RD_BYTE, 16'hFFFF, 16'h0000},
      '{REQ_WR_BYTE, 16'h8001, 16'h00AA},
      '{REQ_WR_WORD, 16'hC000, 16'hFFFF},
      '{REQ_WR_WORD, 16'hFFFE, 16'h8001},
      '{REQ_WR_BYTE, 16'h0401, 16'h0000},
      '{REQ_WR_WORD, 16'h0808, 16'h0000},
      '{REQ_RD_WORD, 16'h8000, 16'h0000},
      '{REQ_WR_BYTE, 16'h0810, 16'h0010},
      '{REQ_WR_WORD, 16'h0800, 16'hFFFF},
      '{REQ_RD_WORD, 16'h0810, 16'h0000},
      '{REQ_WR_WORD, 16'hFFFF, 16'h0000}
   };

   initial begin : stimulus
      int p;
      int idle_modes [4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{35, 35}};
      bit connect_modes [6] = '{1, 1, 0, 1, 1, 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_connected(1'b0);

      foreach (offline_seq[i]) send_access(offline_seq[i]);
      wait_drained();
      write_connected(1'b1);
      foreach (online_seq[i]) send_access(online_seq[i]);

      for (p = 0; p < 6; p++) begin
         wait_drained();
         write_connected(connect_modes[p]);
         sender_idle_pct = idle_modes[p % 4][0];
         receiver_stall_pct = idle_modes[p % 4][1];
         if (p == 0) begin
            send_random(30);
            hold_offs_asked++;
            send_random(40);
            wait_drained();
            send_random(PHASE_ITEMS - 70);
         end else begin
            send_random(PHASE_ITEMS);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (predictor.mismatches == 0 && predictor.pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
